>>> design/dcms_pkg.sv
// ---------------------------------------------------------------------------
// dcms_pkg
// Shared types, codes and position helpers for the drilling cycle sequencer.
// ---------------------------------------------------------------------------
package dcms_pkg;

    // Field widths
    localparam int FW        = 24;  // position and offset words
    localparam int Q_W       = 23;  // peck increment
    localparam int P_W       = 16;  // dwell in ms
    localparam int F_W       = 17;  // feed rate
    localparam int REQ_W     = 3;
    localparam int MOVE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Saturation range of computed positions and peck count cap
    localparam int POS_W      = 24;
    localparam int MAX_PECKS  = 20;
    localparam int PCNT_W     = $clog2(MAX_PECKS + 1);

    // Working width for Z arithmetic: position, peck step and summed offsets
    localparam int WW    = 36;
    localparam int OFS_W = FW + 2;

    // Stream payload widths
    localparam int IN_DATA_W  = 224;
    localparam int OUT_BITS   = 3 * FW + F_W + P_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_DATA_W - OUT_BITS;

    // Queue between front and back (power of two)
    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);

    localparam logic signed [WW-1:0] POS_HI = WW'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] POS_LO = -POS_HI - WW'(1);
    localparam logic signed [WW-1:0] RETRACT_STEP = WW'(1000);
    localparam logic [Q_W-1:0]       DEFAULT_PECK = Q_W'(100);

    // Block request codes
    localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd0;
    localparam logic [REQ_W-1:0] REQ_G81    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_G82    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_G73    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_G83    = 3'd4;

    // Cycle kinds
    localparam logic [1:0] KIND_G81 = 2'd0;
    localparam logic [1:0] KIND_G82 = 2'd1;
    localparam logic [1:0] KIND_G73 = 2'd2;
    localparam logic [1:0] KIND_G83 = 2'd3;

    // Move kinds
    localparam logic [MOVE_W-1:0] MOVE_RAPID = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_FEED  = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_DWELL = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_OFS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_OFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOOL_OFS  = 2'd2;

    // One classified cycle block, ready to expand
    typedef struct packed {
        logic [1:0]              kind;
        logic signed [FW-1:0]    hole_x;
        logic signed [FW-1:0]    hole_y;
        logic signed [POS_W-1:0] start_z;   // saturated current Z
        logic signed [FW-1:0]    ret_r;     // R plane, work coordinates
        logic signed [POS_W-1:0] depth;     // final depth, work coordinates
        logic [Q_W-1:0]          peck;
        logic [P_W-1:0]          dwell;
        logic [F_W-1:0]          feed;
    } job_t;

    // One emitted move
    typedef struct packed {
        logic [MOVE_W-1:0]    kind;
        logic signed [FW-1:0] x;
        logic signed [FW-1:0] y;
        logic signed [FW-1:0] z;
        logic [F_W-1:0]       feed;
        logic [P_W-1:0]       dwell;
        logic                 last;
    } move_t;

    // Clamp to the signed POS_W range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] t;
        begin
            t = v;
            if (v > POS_HI)
            begin
                t = POS_HI;
            end
            else if (v < POS_LO)
            begin
                t = POS_LO;
            end
            return t[POS_W-1:0];
        end
    endfunction

    // Work Z to machine Z
    function automatic logic signed [POS_W-1:0] mach(input logic signed [WW-1:0] work,
                                                     input logic signed [OFS_W-1:0] ofs);
        begin
            return sat_pos(work + WW'(ofs));
        end
    endfunction

    // Saturated position to output field width
    function automatic logic signed [FW-1:0] pos_field(input logic signed [POS_W-1:0] v);
        logic signed [WW-1:0] t;
        begin
            t = WW'(v);
            return t[FW-1:0];
        end
    endfunction

endpackage

>>> design/dcms_front.sv
// ---------------------------------------------------------------------------
// dcms_front
// Accepts program blocks, keeps the modal cycle state and the Z offsets, and
// queues one job per drilling block.
// ---------------------------------------------------------------------------
module dcms_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // block stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [dcms_pkg::IN_DATA_W-1:0]         s_tdata,
    input  logic [dcms_pkg::REQ_W-1:0]             s_tuser,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dcms_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dcms_pkg::FW-1:0]                cfg_data,
    // queue side
    input  logic                                   q_full,
    output logic                                   q_push,
    output dcms_pkg::job_t                         q_job,
    output logic signed [dcms_pkg::OFS_W-1:0]      ofs_sum
);

    localparam int FW    = dcms_pkg::FW;
    localparam int WW    = dcms_pkg::WW;
    localparam int POS_W = dcms_pkg::POS_W;

    // Unpacked block fields
    logic signed [FW-1:0]       block_x, block_y, block_z, block_r;
    logic signed [FW-1:0]       cur_x, cur_y, cur_z;
    logic [dcms_pkg::Q_W-1:0]   block_q;
    logic [dcms_pkg::P_W-1:0]   block_p;
    logic [dcms_pkg::F_W-1:0]   block_f;

    assign block_x = $signed(s_tdata[23:0]);
    assign block_y = $signed(s_tdata[47:24]);
    assign block_z = $signed(s_tdata[71:48]);
    assign block_r = $signed(s_tdata[95:72]);
    assign block_q = s_tdata[118:96];
    assign block_p = s_tdata[134:119];
    assign block_f = s_tdata[151:135];
    assign cur_x   = $signed(s_tdata[175:152]);
    assign cur_y   = $signed(s_tdata[199:176]);
    assign cur_z   = $signed(s_tdata[223:200]);

    // Offsets and modal state
    logic signed [FW-1:0]       work_ofs_reg, extra_ofs_reg, tool_ofs_reg;
    logic signed [dcms_pkg::OFS_W-1:0] ofs_sum_reg;
    logic                       active_reg, active_next;
    logic [1:0]                 kind_reg, kind_next;
    logic signed [FW-1:0]       held_r_reg, held_r_next;
    logic signed [POS_W-1:0]    held_depth_reg, held_depth_next;
    logic [dcms_pkg::Q_W-1:0]   held_peck_reg, held_peck_next;
    logic [dcms_pkg::F_W-1:0]   held_feed_reg, held_feed_next;

    logic                       accept;
    logic                       capture;
    logic [1:0]                 kind_in;
    logic [dcms_pkg::Q_W-1:0]   peck_in;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign ofs_sum   = ofs_sum_reg;

    // Block classification and modal capture
    always_comb
    begin
        case (s_tuser)
            dcms_pkg::REQ_G82: kind_in = dcms_pkg::KIND_G82;
            dcms_pkg::REQ_G73: kind_in = dcms_pkg::KIND_G73;
            dcms_pkg::REQ_G83: kind_in = dcms_pkg::KIND_G83;
            default:           kind_in = dcms_pkg::KIND_G81;
        endcase

        capture = !active_reg || (kind_reg != kind_in);

        // peck cycles fall back to the default increment when Q is absent
        if ((kind_in == dcms_pkg::KIND_G73 || kind_in == dcms_pkg::KIND_G83) && block_q == '0)
        begin
            peck_in = dcms_pkg::DEFAULT_PECK;
        end
        else
        begin
            peck_in = block_q;
        end

        active_next     = active_reg;
        kind_next       = kind_reg;
        held_r_next     = held_r_reg;
        held_depth_next = held_depth_reg;
        held_peck_next  = held_peck_reg;
        held_feed_next  = held_feed_reg;
        q_push          = 1'b0;

        if (accept)
        begin
            case (s_tuser)
                dcms_pkg::REQ_CANCEL:
                begin
                    active_next     = 1'b0;
                    kind_next       = dcms_pkg::KIND_G81;
                    held_r_next     = '0;
                    held_depth_next = '0;
                    held_peck_next  = '0;
                end
                dcms_pkg::REQ_G81, dcms_pkg::REQ_G82, dcms_pkg::REQ_G73, dcms_pkg::REQ_G83:
                begin
                    if (capture)
                    begin
                        active_next     = 1'b1;
                        kind_next       = kind_in;
                        held_r_next     = block_r;
                        held_depth_next = dcms_pkg::sat_pos(WW'(block_z) - WW'(work_ofs_reg));
                        held_peck_next  = peck_in;
                    end
                    if (block_f != '0)
                    begin
                        held_feed_next = block_f;
                    end
                    q_push = 1'b1;
                end
                default:
                begin
                    // other motion: ignored
                end
            endcase
        end

        // Job for the back end
        q_job.kind    = kind_in;
        q_job.hole_x  = (block_x != '0) ? block_x : cur_x;
        q_job.hole_y  = (block_y != '0) ? block_y : cur_y;
        q_job.start_z = dcms_pkg::sat_pos(WW'(cur_z));
        q_job.ret_r   = held_r_next;
        q_job.depth   = held_depth_next;
        q_job.peck    = held_peck_next;
        q_job.dwell   = block_p;
        q_job.feed    = held_feed_next;
    end

    // State, offsets and registered offset sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_ofs_reg   <= '0;
            extra_ofs_reg  <= '0;
            tool_ofs_reg   <= '0;
            ofs_sum_reg    <= '0;
            active_reg     <= 1'b0;
            kind_reg       <= dcms_pkg::KIND_G81;
            held_r_reg     <= '0;
            held_depth_reg <= '0;
            held_peck_reg  <= dcms_pkg::DEFAULT_PECK;
            held_feed_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dcms_pkg::CFG_WORK_OFS:  work_ofs_reg  <= $signed(cfg_data);
                    dcms_pkg::CFG_EXTRA_OFS: extra_ofs_reg <= $signed(cfg_data);
                    dcms_pkg::CFG_TOOL_OFS:  tool_ofs_reg  <= $signed(cfg_data);
                    default:
                    begin
                        // unmapped index
                    end
                endcase
            end
            ofs_sum_reg    <= dcms_pkg::OFS_W'(work_ofs_reg) + dcms_pkg::OFS_W'(extra_ofs_reg)
                              + dcms_pkg::OFS_W'(tool_ofs_reg);
            active_reg     <= active_next;
            kind_reg       <= kind_next;
            held_r_reg     <= held_r_next;
            held_depth_reg <= held_depth_next;
            held_peck_reg  <= held_peck_next;
            held_feed_reg  <= held_feed_next;
        end
    end

endmodule

>>> design/dcms_queue.sv
// ---------------------------------------------------------------------------
// dcms_queue
// Short job queue between the block front end and the move sequencer.
// ---------------------------------------------------------------------------
module dcms_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dcms_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output dcms_pkg::job_t head_job
);

    localparam int QD  = dcms_pkg::QD;
    localparam int QAW = dcms_pkg::QAW;

    dcms_pkg::job_t   mem_reg [QD];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full     = (count_reg == (QAW + 1)'(QD));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/dcms_back.sv
// ---------------------------------------------------------------------------
// dcms_back
// Expands one queued job into its ordered list of moves and drives the
// registered move stream.
// ---------------------------------------------------------------------------
module dcms_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // queue side
    input  logic                                  q_empty,
    input  dcms_pkg::job_t                        q_job,
    output logic                                  q_pop,
    input  logic signed [dcms_pkg::OFS_W-1:0]     ofs_sum,
    // move stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [dcms_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [dcms_pkg::MOVE_W-1:0]           m_tuser,
    output logic                                  m_tlast
);

    localparam int WW     = dcms_pkg::WW;
    localparam int POS_W  = dcms_pkg::POS_W;
    localparam int PCNT_W = dcms_pkg::PCNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XY,       // rapid to hole XY at current Z
        S_R,        // rapid to R plane
        S_FEED,     // feed to depth
        S_DWELL,    // optional dwell at depth
        S_RET,      // closing rapid to R
        S_STEP,     // peck: rapid back down if needed, next target
        S_PFEED,    // peck: feed to target
        S_PBACK,    // peck: partial or full retract
        S_CLOSE     // peck: closing rapid to R
    } state_t;

    state_t                   state_reg;
    dcms_pkg::job_t           job_reg;
    logic signed [POS_W-1:0]  zr_reg, zd_reg, zpos_reg;
    logic signed [WW-1:0]     cur_reg, nxt_reg, h_reg;
    logic [PCNT_W-1:0]        n_reg;
    logic                     down_reg;
    logic                     out_valid_reg;
    dcms_pkg::move_t          out_move_reg;

    logic                     slot_free;
    logic                     emit;
    dcms_pkg::move_t          mv;
    logic signed [WW-1:0]     fin_w, r_w, q_w;
    logic signed [WW-1:0]     nxt_raw, nxt_val, h_val;
    logic signed [POS_W-1:0]  mc_cur, mc_nxt, z_back;

    assign slot_free = !out_valid_reg || m_tready;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_move_reg.kind;
    assign m_tlast  = out_move_reg.last;
    assign m_tdata  = {{dcms_pkg::OUT_PAD{1'b0}}, out_move_reg.dwell, out_move_reg.feed,
                       out_move_reg.z, out_move_reg.y, out_move_reg.x};

    // Peck arithmetic and move selection
    always_comb
    begin
        fin_w = WW'(job_reg.depth);
        r_w   = WW'(job_reg.ret_r);
        q_w   = WW'($signed({1'b0, job_reg.peck}));

        mc_cur = dcms_pkg::mach(cur_reg, ofs_sum);
        mc_nxt = dcms_pkg::mach(nxt_reg, ofs_sum);

        // next peck target, clamped to the final depth; the last allowed peck goes to it
        if (down_reg)
        begin
            nxt_raw = cur_reg - q_w;
            nxt_val = (nxt_raw < fin_w || n_reg == PCNT_W'(dcms_pkg::MAX_PECKS))
                      ? fin_w : nxt_raw;
        end
        else
        begin
            nxt_raw = cur_reg + q_w;
            nxt_val = (nxt_raw > fin_w || n_reg == PCNT_W'(dcms_pkg::MAX_PECKS))
                      ? fin_w : nxt_raw;
        end

        // G73 back-off height, never past R
        if (down_reg)
        begin
            h_val = nxt_reg + dcms_pkg::RETRACT_STEP;
            if (h_val > r_w)
            begin
                h_val = r_w;
            end
        end
        else
        begin
            h_val = nxt_reg - dcms_pkg::RETRACT_STEP;
            if (h_val < r_w)
            begin
                h_val = r_w;
            end
        end

        z_back = (job_reg.kind == dcms_pkg::KIND_G73) ? dcms_pkg::mach(h_reg, ofs_sum) : zr_reg;

        emit     = 1'b0;
        mv       = '0;
        mv.x     = job_reg.hole_x;
        mv.y     = job_reg.hole_y;
        mv.kind  = dcms_pkg::MOVE_RAPID;
        case (state_reg)
            S_XY:
            begin
                emit = 1'b1;
                mv.z = dcms_pkg::pos_field(job_reg.start_z);
            end
            S_R:
            begin
                emit = 1'b1;
                mv.z = dcms_pkg::pos_field(zr_reg);
            end
            S_FEED:
            begin
                emit    = 1'b1;
                mv.kind = dcms_pkg::MOVE_FEED;
                mv.z    = dcms_pkg::pos_field(zd_reg);
                mv.feed = job_reg.feed;
            end
            S_DWELL:
            begin
                emit     = 1'b1;
                mv.kind  = dcms_pkg::MOVE_DWELL;
                mv.z     = dcms_pkg::pos_field(zd_reg);
                mv.dwell = job_reg.dwell;
            end
            S_RET, S_CLOSE:
            begin
                emit    = 1'b1;
                mv.z    = dcms_pkg::pos_field(zr_reg);
                mv.last = 1'b1;
            end
            S_STEP:
            begin
                emit = (mc_cur != zpos_reg);
                mv.z = dcms_pkg::pos_field(mc_cur);
            end
            S_PFEED:
            begin
                emit    = 1'b1;
                mv.kind = dcms_pkg::MOVE_FEED;
                mv.z    = dcms_pkg::pos_field(mc_nxt);
                mv.feed = job_reg.feed;
            end
            S_PBACK:
            begin
                emit = 1'b1;
                mv.z = dcms_pkg::pos_field(z_back);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit && slot_free)
            begin
                out_valid_reg <= 1'b1;
                out_move_reg  <= mv;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= q_job;
                        state_reg <= S_XY;
                    end
                end
                S_XY:
                begin
                    if (slot_free)
                    begin
                        zr_reg    <= dcms_pkg::mach(r_w, ofs_sum);
                        state_reg <= S_R;
                    end
                end
                S_R:
                begin
                    if (slot_free)
                    begin
                        zd_reg    <= dcms_pkg::mach(fin_w, ofs_sum);
                        zpos_reg  <= zr_reg;
                        cur_reg   <= r_w;
                        n_reg     <= PCNT_W'(1);
                        down_reg  <= (fin_w < r_w);
                        if (job_reg.kind == dcms_pkg::KIND_G81 ||
                            job_reg.kind == dcms_pkg::KIND_G82)
                        begin
                            state_reg <= S_FEED;
                        end
                        else
                        begin
                            state_reg <= S_STEP;
                        end
                    end
                end
                S_FEED:
                begin
                    if (slot_free)
                    begin
                        if (job_reg.kind == dcms_pkg::KIND_G82 && job_reg.dwell != '0)
                        begin
                            state_reg <= S_DWELL;
                        end
                        else
                        begin
                            state_reg <= S_RET;
                        end
                    end
                end
                S_DWELL:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_RET;
                    end
                end
                S_RET, S_CLOSE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_STEP:
                begin
                    if (slot_free)
                    begin
                        if (mc_cur != zpos_reg)
                        begin
                            zpos_reg <= mc_cur;
                        end
                        nxt_reg   <= nxt_val;
                        state_reg <= S_PFEED;
                    end
                end
                S_PFEED:
                begin
                    if (slot_free)
                    begin
                        zpos_reg <= mc_nxt;
                        cur_reg  <= nxt_reg;
                        h_reg    <= h_val;
                        if (nxt_reg == fin_w)
                        begin
                            state_reg <= S_CLOSE;
                        end
                        else
                        begin
                            state_reg <= S_PBACK;
                        end
                    end
                end
                S_PBACK:
                begin
                    if (slot_free)
                    begin
                        zpos_reg  <= z_back;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_STEP;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The cycle always closes with a rapid
    a_last_is_rapid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_move_reg.last |-> out_move_reg.kind == dcms_pkg::MOVE_RAPID)
        else $error("last move is not a rapid");

    // A dwell item carries a nonzero duration
    a_dwell_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_move_reg.kind == dcms_pkg::MOVE_DWELL |-> out_move_reg.dwell != '0)
        else $error("dwell without duration");

    // Peck count stays within the cap
    a_peck_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STEP |-> n_reg >= PCNT_W'(1) && n_reg <= PCNT_W'(dcms_pkg::MAX_PECKS))
        else $error("peck count out of range");

    // No retract is taken once the final depth is reached
    a_no_retract_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PBACK |-> cur_reg != fin_w)
        else $error("retract after final depth");

endmodule

>>> design/drill_cycle_move_sequencer.sv
// ---------------------------------------------------------------------------
// drill_cycle_move_sequencer
// Canned drilling cycle expander (G81, G82, G73, G83) with modal cycle state.
// ---------------------------------------------------------------------------
// A block taken while the sequencer is idle is written into the job queue, loaded
//   into the job register by the IDLE state, and its first move is then registered.
// Moves leave the output register as m_tready allows; the sequencer also spends
//   a state with no move on each idle step and on each peck that needs no rapid
//   back down (at most 1 + 3 * MAX_PECKS moves per block).
// A two-entry job queue lets the next block be taken while moves still drain.
// Reset: offsets and modal state clear, held peck 100 um, no stored moves.
// ---------------------------------------------------------------------------
module drill_cycle_move_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // block input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // block_x, block_y, block_z, block_r, block_q, block_p, block_f,
    // cur_x, cur_y, cur_z
    input  logic [dcms_pkg::IN_DATA_W-1:0]        s_tdata,
    // req_type
    input  logic [dcms_pkg::REQ_W-1:0]            s_tuser,
    // move output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pos_x, pos_y, pos_z, feed, dwell_ms, zero padding
    output logic [dcms_pkg::OUT_DATA_W-1:0]       m_tdata,
    // move_kind
    output logic [dcms_pkg::MOVE_W-1:0]           m_tuser,
    output logic                                  m_tlast,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dcms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dcms_pkg::FW-1:0]               cfg_data
);

    logic                                q_full, q_push, q_empty, q_pop;
    dcms_pkg::job_t                      push_job, head_job;
    logic signed [dcms_pkg::OFS_W-1:0]   ofs_sum;

    // Block intake and modal state
    dcms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .ofs_sum   (ofs_sum)
    );

    // Job queue
    dcms_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    // Move sequencer
    dcms_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .ofs_sum  (ofs_sum),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> test/drill_cycle_move_sequencer_chk.sv
// ---------------------------------------------------------------------------
// drill_cycle_move_sequencer_chk
// Watches the block, config and move channels of the drilling cycle
// sequencer. Every accepted block is expanded into its expected move list,
// and every accepted move is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module drill_cycle_move_sequencer_chk (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [dcms_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [dcms_pkg::REQ_W-1:0]        s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [dcms_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic [dcms_pkg::MOVE_W-1:0]       m_tuser,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [dcms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dcms_pkg::FW-1:0]           cfg_data,
    output int                                errors,
    output int                                pending,
    output int                                moves_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import dcms_pkg::*;

    localparam longint Z_HI       = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint Z_LO       = -Z_HI - 1;
    localparam longint BACKOFF    = 1000;
    localparam longint PECK_DFLT  = 100;
    localparam int     MOVE_CAP   = 64;
    localparam int     SHOW_MAX   = 40;

    // Z offsets as last written
    longint ofs_work, ofs_extra, ofs_tool;

    // Modal cycle state
    bit                cyc_on;
    logic [1:0]        cyc_kind;
    longint            hold_r, hold_depth, hold_peck;
    logic [F_W-1:0]    hold_feed;

    // Current hole and moves produced by the current block
    longint            hole_x, hole_y;
    int                blk_moves;
    int                shown;

    // Moves still owed by the block, oldest first
    move_t             moves_due[$];

    function automatic longint sx24(input logic [FW-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clamp_pos(input longint v);
        if (v > Z_HI)
        begin
            return Z_HI;
        end
        if (v < Z_LO)
        begin
            return Z_LO;
        end
        return v;
    endfunction

    function automatic longint to_machine(input longint w);
        return clamp_pos(w + ofs_work + ofs_extra + ofs_tool);
    endfunction

    task automatic add_move(input logic [MOVE_W-1:0] k, input longint z,
                            input logic [F_W-1:0] f, input logic [P_W-1:0] dw);
        move_t m;
        begin
            if (blk_moves < MOVE_CAP)
            begin
                m.kind  = k;
                m.x     = hole_x[FW-1:0];
                m.y     = hole_y[FW-1:0];
                m.z     = z[FW-1:0];
                m.feed  = f;
                m.dwell = dw;
                m.last  = 1'b0;
                moves_due.push_back(m);
                blk_moves++;
            end
        end
    endtask

    // Expand one program block into the moves it must produce
    task automatic expand_block(input logic [REQ_W-1:0] req,
                                input logic [IN_DATA_W-1:0] d);
        longint         bx, by, zr, zd, fin, rr, cur, zpos, q, nxt, brk;
        logic [Q_W-1:0] q_in;
        logic [P_W-1:0] p_in;
        logic [F_W-1:0] f_in;
        logic [1:0]     kind;
        bit             down, pecking, done;
        int             n;
        begin
            if (req == REQ_CANCEL)
            begin
                cyc_on     = 1'b0;
                cyc_kind   = KIND_G81;
                hold_r     = 0;
                hold_depth = 0;
                hold_peck  = 0;
            end
            else if (req <= REQ_G83)
            begin
                kind    = 2'(req - REQ_G81);
                pecking = (kind == KIND_G73) || (kind == KIND_G83);
                bx      = sx24(d[23:0]);
                by      = sx24(d[47:24]);
                q_in    = d[118:96];
                p_in    = d[134:119];
                f_in    = d[151:135];
                // zero XY words keep the current position
                hole_x  = (bx != 0) ? bx : sx24(d[175:152]);
                hole_y  = (by != 0) ? by : sx24(d[199:176]);

                // R, depth and Q are modal: captured on entry or kind change
                if (!cyc_on || cyc_kind != kind)
                begin
                    cyc_on     = 1'b1;
                    cyc_kind   = kind;
                    hold_r     = sx24(d[95:72]);
                    hold_depth = clamp_pos(sx24(d[71:48]) - ofs_work);
                    if (pecking)
                    begin
                        hold_peck = (q_in != 0) ? longint'(q_in) : PECK_DFLT;
                    end
                    else
                    begin
                        hold_peck = longint'(q_in);
                    end
                end
                if (f_in != 0)
                begin
                    hold_feed = f_in;
                end

                blk_moves = 0;
                zr = to_machine(hold_r);
                add_move(MOVE_RAPID, clamp_pos(sx24(d[223:200])), '0, '0);
                add_move(MOVE_RAPID, zr, '0, '0);

                if (!pecking)
                begin
                    zd = to_machine(hold_depth);
                    add_move(MOVE_FEED, zd, hold_feed, '0);
                    if (kind == KIND_G82 && p_in != 0)
                    begin
                        add_move(MOVE_DWELL, zd, '0, p_in);
                    end
                    add_move(MOVE_RAPID, zr, '0, '0);
                end
                else
                begin
                    fin  = hold_depth;
                    rr   = hold_r;
                    cur  = rr;
                    zpos = zr;
                    q    = hold_peck;
                    down = fin < rr;
                    done = 1'b0;
                    for (n = 1; n <= MAX_PECKS && !done; n++)
                    begin
                        // next peck depth, last allowed peck goes to the bottom
                        if (down)
                        begin
                            nxt = cur - q;
                            if (nxt < fin || n == MAX_PECKS)
                            begin
                                nxt = fin;
                            end
                        end
                        else
                        begin
                            nxt = cur + q;
                            if (nxt > fin || n == MAX_PECKS)
                            begin
                                nxt = fin;
                            end
                        end
                        if (to_machine(cur) != zpos)
                        begin
                            zpos = to_machine(cur);
                            add_move(MOVE_RAPID, zpos, '0, '0);
                        end
                        zpos = to_machine(nxt);
                        add_move(MOVE_FEED, zpos, hold_feed, '0);
                        cur = nxt;
                        if (cur == fin)
                        begin
                            add_move(MOVE_RAPID, zr, '0, '0);
                            done = 1'b1;
                        end
                        else
                        begin
                            // G73 backs off 1 mm but never past R
                            if (kind == KIND_G73)
                            begin
                                brk = down ? cur + BACKOFF : cur - BACKOFF;
                                if (down && brk > rr)
                                begin
                                    brk = rr;
                                end
                                if (!down && brk < rr)
                                begin
                                    brk = rr;
                                end
                                zpos = to_machine(brk);
                            end
                            else
                            begin
                                zpos = zr;
                            end
                            add_move(MOVE_RAPID, zpos, '0, '0);
                        end
                    end
                end
                if (blk_moves > 0)
                begin
                    moves_due[moves_due.size() - 1].last = 1'b1;
                end
            end
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            errors++;
            if (shown < SHOW_MAX)
            begin
                shown++;
                $display("%0t: move %0d %s expected %0h actual %0h",
                         $time, moves_seen, name, e, a);
            end
        end
    endtask

    // Channel monitor: compare moves, track config, expand blocks
    always @(posedge clk or negedge rst_n)
    begin : monitor
        move_t exp_mv;
        if (!rst_n)
        begin
            ofs_work   = 0;
            ofs_extra  = 0;
            ofs_tool   = 0;
            cyc_on     = 1'b0;
            cyc_kind   = KIND_G81;
            hold_r     = 0;
            hold_depth = 0;
            hold_peck  = PECK_DFLT;
            hold_feed  = '0;
            hole_x     = 0;
            hole_y     = 0;
            blk_moves  = 0;
            shown      = 0;
            errors     = 0;
            pending    = 0;
            moves_seen = 0;
            moves_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (moves_due.size() == 0)
                begin
                    errors++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display("%0t: unexpected move expected none actual kind %0h z %0h",
                                 $time, m_tuser, m_tdata[71:48]);
                    end
                end
                else
                begin
                    exp_mv = moves_due.pop_front();
                    cmp_field("kind",  32'(exp_mv.kind),             32'(m_tuser));
                    cmp_field("pos_x", 32'($unsigned(exp_mv.x)),     32'(m_tdata[23:0]));
                    cmp_field("pos_y", 32'($unsigned(exp_mv.y)),     32'(m_tdata[47:24]));
                    cmp_field("pos_z", 32'($unsigned(exp_mv.z)),     32'(m_tdata[71:48]));
                    cmp_field("feed",  32'(exp_mv.feed),             32'(m_tdata[88:72]));
                    cmp_field("dwell", 32'(exp_mv.dwell),            32'(m_tdata[104:89]));
                    cmp_field("last",  32'(exp_mv.last),             32'(m_tlast));
                end
                moves_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WORK_OFS:  ofs_work  = sx24(cfg_data);
                    CFG_EXTRA_OFS: ofs_extra = sx24(cfg_data);
                    CFG_TOOL_OFS:  ofs_tool  = sx24(cfg_data);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expand_block(s_tuser, s_tdata);
            end
            pending = moves_due.size();
        end
    end

endmodule

>>> test/drill_cycle_move_sequencer_tb.sv
// ---------------------------------------------------------------------------
// drill_cycle_move_sequencer_tb
// Drives program blocks and Z offset writes into the drilling cycle
// sequencer with random gaps and output stalls; the checker beside it
// predicts every move and reports mismatches.
// ---------------------------------------------------------------------------
module drill_cycle_move_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcms_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_LEN   = 38;
    localparam int SETTLE      = 16;
    localparam int OFS_MAX     = 8388607;
    localparam int OFS_MIN     = -8388608;

    // Non-cycle motion codes
    localparam logic [REQ_W-1:0] REQ_OTHER  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    typedef struct {
        logic [REQ_W-1:0] req;
        logic [FW-1:0]    x, y, z, r;
        logic [Q_W-1:0]   q;
        logic [P_W-1:0]   p;
        logic [F_W-1:0]   f;
        logic [FW-1:0]    cx, cy, cz;
    } block_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [REQ_W-1:0]       s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [MOVE_W-1:0]      m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [FW-1:0]          cfg_data  = '0;

    int errors, pending, moves_seen;
    int quiet    = 0;
    int settings = 0;
    int sent [8] = '{default: 0};
    bit idle_on  = 1'b1;

    drill_cycle_move_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    drill_cycle_move_sequencer_chk chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending),
        .moves_seen (moves_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: too long without any word moving on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, quiet);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Move sink: random stall before each word unless idle gaps are off
    initial
    begin : move_sink
        int w;
        forever
        begin
            w = idle_on ? $urandom_range(0, 16) : 0;
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    function automatic int rand_span(input int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    // Mostly well-formed cycle blocks of the hinted kind, some raw noise
    function automatic block_t rand_block(input logic [REQ_W-1:0] hint);
        block_t b;
        int     sel, rr;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
            begin
                b.req = REQ_W'($urandom);
                b.x   = FW'($urandom);
                b.y   = FW'($urandom);
                b.z   = FW'($urandom);
                b.r   = FW'($urandom);
                b.q   = Q_W'($urandom);
                b.p   = P_W'($urandom);
                b.f   = F_W'($urandom);
                b.cx  = FW'($urandom);
                b.cy  = FW'($urandom);
                b.cz  = FW'($urandom);
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                begin
                    b.req = REQ_CANCEL;
                end
                else if (sel < 12)
                begin
                    b.req = REQ_W'($urandom_range(REQ_OTHER, REQ_SPARE7));
                end
                else if (sel < 82)
                begin
                    b.req = hint;
                end
                else
                begin
                    b.req = REQ_W'($urandom_range(REQ_G81, REQ_G83));
                end
                b.cx = FW'(rand_span(200000));
                b.cy = FW'(rand_span(200000));
                b.cz = FW'(rand_span(50000));
                b.x  = ($urandom_range(0, 3) == 0) ? '0 : FW'(rand_span(200000));
                b.y  = ($urandom_range(0, 3) == 0) ? '0 : FW'(rand_span(200000));
                rr   = int'($urandom_range(0, 6000)) - 1000;
                b.r  = FW'(rr);
                // mostly downward holes, some upward and some with Z on R
                sel = $urandom_range(0, 99);
                if (sel < 70)
                begin
                    b.z = FW'(rr - int'($urandom_range(0, 25000)));
                end
                else if (sel < 85)
                begin
                    b.z = FW'(rr + int'($urandom_range(1, 8000)));
                end
                else
                begin
                    b.z = FW'(rr);
                end
                b.q = ($urandom_range(0, 4) == 0) ? '0 : Q_W'($urandom_range(1, 4000));
                b.p = ($urandom_range(0, 2) == 0) ? '0 : P_W'($urandom_range(1, 3000));
                b.f = ($urandom_range(0, 2) == 0) ? '0 : F_W'($urandom);
            end
            return b;
        end
    endfunction

    // Present one block; valid is left high so back-to-back words need no gap
    task automatic send_block(input block_t b);
        int w;
        begin
            w = idle_on ? $urandom_range(0, 16) : 0;
            if (w > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (w) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= b.req;
            s_tdata  <= {b.cz, b.cy, b.cx, b.f, b.p, b.q, b.r, b.z, b.y, b.x};
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            sent[b.req]++;
        end
    endtask

    task automatic drill(input logic [REQ_W-1:0] req, input int x, input int y,
                         input int z, input int r, input int q, input int p,
                         input int f, input int cx, input int cy, input int cz);
        block_t b;
        begin
            b.req = req;
            b.x   = FW'(x);
            b.y   = FW'(y);
            b.z   = FW'(z);
            b.r   = FW'(r);
            b.q   = Q_W'(q);
            b.p   = P_W'(p);
            b.f   = F_W'(f);
            b.cx  = FW'(cx);
            b.cy  = FW'(cy);
            b.cz  = FW'(cz);
            send_block(b);
        end
    endtask

    // Stop sending, let every owed move drain, then let the pipe settle
    task automatic drain_moves();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_offsets(input int w, input int e, input int t);
        logic [FW-1:0]        vals [3];
        logic [CFG_IDX_W-1:0] regs [3];
        int                   i;
        begin
            vals[0] = FW'(w);
            vals[1] = FW'(e);
            vals[2] = FW'(t);
            regs[0] = CFG_WORK_OFS;
            regs[1] = CFG_EXTRA_OFS;
            regs[2] = CFG_TOOL_OFS;
            for (i = 0; i < 3; i++)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= regs[i];
                cfg_data  <= vals[i];
                @(posedge clk);
                while (!cfg_ready) @(posedge clk);
            end
            cfg_valid <= 1'b0;
            settings++;
        end
    endtask

    initial
    begin : stimulus
        logic [REQ_W-1:0] hint;
        int               ph, k;
        hint = REQ_G81;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset offsets, plain cycles, modal reuse, dwell
        drill(REQ_G81, 1000, 2000, -5000, 1000, 0, 0, 500, 0, 0, 10000);
        drill(REQ_G81, 0, 0, -9999, 7, 0, 0, 0, 3000, 4000, 1000);
        drill(REQ_G82, 1500, -1500, -3000, 500, 0, 250, 0, 0, 0, 1000);
        drill(REQ_G82, 2500, -2500, -7000, 900, 0, 0, 0, 0, 0, 500);
        drill(REQ_G82, 3500, -3500, -7000, 900, 0, 65535, 131071, 0, 0, 500);
        // pecks: default Q, uneven Q, peck cap, kind change, modal Q
        drill(REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drill(REQ_G73, 100, 100, -800, 200, 0, 0, 300, 0, 0, 2000);
        drill(REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drill(REQ_G73, 200, 200, -1000, 0, 300, 0, 0, 0, 0, 2000);
        drill(REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drill(REQ_G73, 300, 300, -100000, 0, 1, 0, 0, 0, 0, 0);
        drill(REQ_G83, 400, 400, -2500, 100, 700, 0, 0, 0, 0, 500);
        drill(REQ_G83, 500, 500, -9000, 300, 5, 0, 0, 0, 0, 500);
        drill(REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drill(REQ_G83, 600, 600, -50000, 0, 1, 0, 0, 0, 0, 0);
        // upward pecks and final depth equal to R
        drill(REQ_G73, 700, 700, 5000, 0, 1500, 0, 0, 0, 0, -1000);
        drill(REQ_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drill(REQ_G83, 800, 800, 3000, 1000, 0, 0, 0, 0, 0, 0);
        drill(REQ_G73, 900, 900, 2000, 2000, 400, 0, 0, 0, 0, 0);
        drill(REQ_G83, 950, 950, -2000, -2000, 400, 0, 0, 0, 0, 0);
        // ignored motion codes
        drill(REQ_OTHER, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10);
        drill(REQ_SPARE6, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10);
        drill(REQ_SPARE7, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10);
        // field extremes
        drill(REQ_G81, OFS_MAX, OFS_MIN, OFS_MIN, OFS_MAX, 8388607, 65535, 131071,
              OFS_MIN, OFS_MAX, OFS_MAX);
        drill(REQ_G83, OFS_MIN, OFS_MAX, OFS_MAX, OFS_MIN, 8388607, 65535, 131071,
              OFS_MAX, OFS_MIN, OFS_MIN);
        drill(REQ_G73, -1, -1, OFS_MIN, OFS_MAX, 8388607, 0, 1, -1, -1, -1);

        // Random phases, each under its own offset setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_moves();
            case (ph)
                0: set_offsets(1500, -250, 42000);
                1: set_offsets(OFS_MAX, OFS_MAX, OFS_MAX);
                2: set_offsets(OFS_MIN, OFS_MIN, OFS_MIN);
                3: set_offsets(OFS_MAX, OFS_MIN, 0);
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        set_offsets(rand_span(20000), rand_span(20000), rand_span(20000));
                    end
                    else
                    begin
                        set_offsets(int'($urandom), int'($urandom), int'($urandom));
                    end
                end
            endcase
            idle_on = (ph != 2) && (ph != 5);
            for (k = 0; k < PHASE_LEN; k++)
            begin
                if (k % 6 == 0)
                begin
                    hint = REQ_W'($urandom_range(REQ_G81, REQ_G83));
                end
                send_block(rand_block(hint));
            end
        end
        drain_moves();

        $display("covered blocks: %0d G81, %0d G82, %0d G73, %0d G83, %0d cancel, %0d other",
                 sent[REQ_G81], sent[REQ_G82], sent[REQ_G73], sent[REQ_G83],
                 sent[REQ_CANCEL], sent[REQ_OTHER] + sent[REQ_SPARE6] + sent[REQ_SPARE7]);
        $display("%0d offset settings, %0d moves compared, %0d mismatches",
                 settings, moves_seen, errors);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
